FILE: hw/rtl/hsvc_pkg.sv
//------------------------------------------------------------------------------
// hsvc_pkg
// Shared types and constants for the RGB/HSV color converter pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

    localparam int unsigned QuoW    = 8;      // quotient bits of every divide
    localparam int unsigned BitsPerStage = 2; // quotient bits resolved per stage
    localparam int unsigned DivANumW = 22;    // hue numerator / xf product
    localparam int unsigned DivADenW = 14;    // chroma or 255*60
    localparam int unsigned DivBNumW = 16;    // 255*chroma
    localparam int unsigned DivBDenW = 8;     // max channel

    localparam logic [DivADenW-1:0] XfDen = 14'd15300;

    typedef enum logic {
        OP_RGB2HSV = 1'b0,
        OP_HSV2RGB = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        HC_GRAY    = 3'd0,
        HC_RED_POS = 3'd1,
        HC_RED_NEG = 3'd2,
        HC_GRN_POS = 3'd3,
        HC_GRN_NEG = 3'd4,
        HC_BLU_POS = 3'd5,
        HC_BLU_NEG = 3'd6
    } hue_case_t;

    // sideband that travels with each pixel through the pipeline
    typedef struct packed {
        op_t         op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  bright;
        hue_case_t   hcase;
        logic [7:0]  mx;
        logic [7:0]  chroma;
        logic [13:0] hnum;
        logic [15:0] snum;
        logic [2:0]  sector;
        logic [5:0]  wgt;
        logic [15:0] vs;
        logic [15:0] vms;
        logic [7:0]  cf;
        logic [7:0]  mf;
    } pix_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsvc_div.sv
//------------------------------------------------------------------------------
// hsvc_div
// Pipelined restoring divider, BPS quotient bits per stage. The quotient
// must fit in QW bits; the partial remainder and divisor ride along each stage.
//------------------------------------------------------------------------------
`default_nettype none

module hsvc_div #(
    parameter int unsigned NW  = hsvc_pkg::DivANumW,
    parameter int unsigned DW  = hsvc_pkg::DivADenW,
    parameter int unsigned QW  = hsvc_pkg::QuoW,
    parameter int unsigned BPS = hsvc_pkg::BitsPerStage
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo,
    output logic      [NW-1:0] rem
);

    localparam int unsigned NST = QW / BPS;

    logic [NW-1:0] rem_reg [NST];
    logic [DW-1:0] den_reg [NST];
    logic [QW-1:0] quo_reg [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (s == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            for (int j = 0; j < BPS; j++)
            begin
                if ((rem_next >> (QW - 1 - s * BPS - j)) >= NW'(den_in))
                begin
                    rem_next = rem_next - (NW'(den_in) << (QW - 1 - s * BPS - j));
                    quo_next[QW - 1 - s * BPS - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[NST-1];
    assign rem = rem_reg[NST-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_hsv_color_converter.sv
// Pipeline: 2 prep stages, 4 divider stages at 2 quotient bits each and
// 1 output stage lie between input transaction and result.
// Throughput: one pixel per cycle; the whole pipeline holds when the
// output register is full and not taken.
// Reset: rst_n clears all valid bits asynchronously; data regs are not reset.
//------------------------------------------------------------------------------
// rgb_hsv_color_converter
// Per-pixel RGB<->HSV converter, fully pipelined, integer exact.
//------------------------------------------------------------------------------
`default_nettype none

module rgb_hsv_color_converter #(
    parameter int unsigned QW  = hsvc_pkg::QuoW,
    parameter int unsigned BPS = hsvc_pkg::BitsPerStage
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic [8:0] hue_in,
    input  wire logic [7:0] sat_in,
    input  wire logic [7:0] bright_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic [8:0]      hue_out,
    output logic [7:0]      sat_out,
    output logic [7:0]      bright_out
);

    localparam int unsigned NDIV = QW / BPS;
    localparam int unsigned NSB  = NDIV + 2;  // sideband stages before output

    logic en;
    logic [NSB-1:0] vld_reg;
    hsvc_pkg::pix_t sb_reg [NSB];
    hsvc_pkg::pix_t s1_next;
    hsvc_pkg::pix_t s2_next;

    logic out_valid_reg;
    hsvc_pkg::op_t op_out_reg;
    logic [7:0] red_reg, green_reg, blue_reg, sat_reg, bright_reg;
    logic [8:0] hue_reg;
    logic [7:0] red_next, green_next, blue_next, sat_next, bright_next;
    logic [8:0] hue_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: max/min, sector, products ----------------
    logic [7:0] mx, mn, chroma, absd;
    logic [8:0] hr, tt;
    logic [6:0] tdist;
    hsvc_pkg::hue_case_t hcase;

    always_comb
    begin
        mx = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx) mx = blue_in;
        mn = red_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn) mn = blue_in;
        chroma = mx - mn;

        priority if (chroma == 8'd0)
        begin
            hcase = hsvc_pkg::HC_GRAY;
            absd  = 8'd0;
        end
        else if (mx == red_in)
        begin
            hcase = (green_in >= blue_in) ? hsvc_pkg::HC_RED_POS : hsvc_pkg::HC_RED_NEG;
            absd  = (green_in >= blue_in) ? green_in - blue_in : blue_in - green_in;
        end
        else if (mx == green_in)
        begin
            hcase = (blue_in >= red_in) ? hsvc_pkg::HC_GRN_POS : hsvc_pkg::HC_GRN_NEG;
            absd  = (blue_in >= red_in) ? blue_in - red_in : red_in - blue_in;
        end
        else
        begin
            hcase = (red_in >= green_in) ? hsvc_pkg::HC_BLU_POS : hsvc_pkg::HC_BLU_NEG;
            absd  = (red_in >= green_in) ? red_in - green_in : green_in - red_in;
        end

        hr = (hue_in >= 9'd360) ? hue_in - 9'd360 : hue_in;
        priority if (hr >= 9'd240) tt = hr - 9'd240;
        else if (hr >= 9'd120)     tt = hr - 9'd120;
        else                       tt = hr;
        tdist = (tt >= 9'd60) ? 7'(tt - 9'd60) : 7'(9'd60 - tt);

        s1_next        = '0;
        s1_next.op     = hsvc_pkg::op_t'(operation);
        s1_next.red    = red_in;
        s1_next.green  = green_in;
        s1_next.blue   = blue_in;
        s1_next.hue    = hue_in;
        s1_next.sat    = sat_in;
        s1_next.bright = bright_in;
        s1_next.hcase  = hcase;
        s1_next.mx     = mx;
        s1_next.chroma = chroma;
        s1_next.hnum   = ({6'd0, absd} << 6) - ({6'd0, absd} << 2);
        s1_next.snum   = ({8'd0, chroma} << 8) - {8'd0, chroma};
        priority if (hr >= 9'd300) s1_next.sector = 3'd5;
        else if (hr >= 9'd240)     s1_next.sector = 3'd4;
        else if (hr >= 9'd180)     s1_next.sector = 3'd3;
        else if (hr >= 9'd120)     s1_next.sector = 3'd2;
        else if (hr >= 9'd60)      s1_next.sector = 3'd1;
        else                       s1_next.sector = 3'd0;
        s1_next.wgt    = 6'(7'd60 - tdist);
        s1_next.vs     = bright_in * sat_in;
        s1_next.vms    = bright_in * (8'd255 - sat_in);
    end

    // ---------------- stage 2: divide by 255, xf product ----------------
    logic [16:0] vs1, vms1;
    logic [21:0] prod;

    always_comb
    begin
        vs1  = {1'b0, sb_reg[0].vs} + 17'd1;
        vms1 = {1'b0, sb_reg[0].vms} + 17'd1;
        s2_next    = sb_reg[0];
        s2_next.cf = 8'((vs1 + (vs1 >> 8)) >> 8);
        s2_next.mf = 8'((vms1 + (vms1 >> 8)) >> 8);
    end

    assign prod = sb_reg[1].vs * sb_reg[1].wgt;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= s1_next;
            sb_reg[1] <= s2_next;
            for (int i = 2; i < NSB; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // ---------------- divider stages ----------------
    logic [hsvc_pkg::DivANumW-1:0] diva_num, diva_rem;
    logic [hsvc_pkg::DivADenW-1:0] diva_den;
    logic [QW-1:0] diva_quo, divb_quo;
    logic [hsvc_pkg::DivBNumW-1:0] divb_rem;

    assign diva_num = (sb_reg[1].op == hsvc_pkg::OP_HSV2RGB) ? prod
                    : hsvc_pkg::DivANumW'(sb_reg[1].hnum);
    assign diva_den = (sb_reg[1].op == hsvc_pkg::OP_HSV2RGB) ? hsvc_pkg::XfDen
                    : hsvc_pkg::DivADenW'(sb_reg[1].chroma);

    hsvc_div #(
        .NW (hsvc_pkg::DivANumW),
        .DW (hsvc_pkg::DivADenW),
        .QW (QW),
        .BPS(BPS)
    ) u_div_a (
        .clk(clk),
        .en (en),
        .num(diva_num),
        .den(diva_den),
        .quo(diva_quo),
        .rem(diva_rem)
    );

    hsvc_div #(
        .NW (hsvc_pkg::DivBNumW),
        .DW (hsvc_pkg::DivBDenW),
        .QW (QW),
        .BPS(BPS)
    ) u_div_b (
        .clk(clk),
        .en (en),
        .num(sb_reg[1].snum),
        .den(sb_reg[1].mx),
        .quo(divb_quo),
        .rem(divb_rem)
    );

    // ---------------- output stage ----------------
    hsvc_pkg::pix_t fs;
    logic [8:0] q9;
    logic       rnz;
    logic [7:0] xf, cr, cg, cb;

    assign fs  = sb_reg[NSB-1];
    assign q9  = 9'(diva_quo);
    assign rnz = (diva_rem != '0);
    assign xf  = 8'(diva_quo);

    always_comb
    begin
        unique case (fs.sector)
            3'd0:    begin cr = fs.cf; cg = xf;    cb = 8'd0;  end
            3'd1:    begin cr = xf;    cg = fs.cf; cb = 8'd0;  end
            3'd2:    begin cr = 8'd0;  cg = fs.cf; cb = xf;    end
            3'd3:    begin cr = 8'd0;  cg = xf;    cb = fs.cf; end
            3'd4:    begin cr = xf;    cg = 8'd0;  cb = fs.cf; end
            default: begin cr = fs.cf; cg = 8'd0;  cb = xf;    end
        endcase

        if (fs.op == hsvc_pkg::OP_HSV2RGB)
        begin
            red_next    = cr + fs.mf;
            green_next  = cg + fs.mf;
            blue_next   = cb + fs.mf;
            hue_next    = fs.hue;
            sat_next    = fs.sat;
            bright_next = fs.bright;
        end
        else
        begin
            red_next    = fs.red;
            green_next  = fs.green;
            blue_next   = fs.blue;
            bright_next = fs.mx;
            sat_next    = (fs.mx == 8'd0) ? 8'd0 : divb_quo;
            unique case (fs.hcase)
                hsvc_pkg::HC_RED_POS: hue_next = q9;
                hsvc_pkg::HC_RED_NEG: hue_next = (q9 == 9'd0) ? 9'd0 : 9'd360 - q9;
                hsvc_pkg::HC_GRN_POS: hue_next = 9'd120 + q9;
                hsvc_pkg::HC_GRN_NEG: hue_next = 9'd120 - q9 - {8'd0, rnz};
                hsvc_pkg::HC_BLU_POS: hue_next = 9'd240 + q9;
                hsvc_pkg::HC_BLU_NEG: hue_next = 9'd240 - q9 - {8'd0, rnz};
                default:              hue_next = 9'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSB-2:0], in_valid};
            out_valid_reg <= vld_reg[NSB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_out_reg <= fs.op;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign hue_out    = hue_reg;
    assign sat_out    = sat_reg;
    assign bright_out = bright_reg;

    // ---------------- assertions ----------------
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_out_reg == hsvc_pkg::OP_RGB2HSV |-> hue_out < 9'd360)
        else $error("computed hue out of range");

    a_value_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_out_reg == hsvc_pkg::OP_RGB2HSV |->
            bright_out >= red_out && bright_out >= green_out && bright_out >= blue_out)
        else $error("value is not the max channel");

    a_rgb_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_out_reg == hsvc_pkg::OP_HSV2RGB |->
            red_out <= bright_out && green_out <= bright_out && blue_out <= bright_out)
        else $error("rgb channel exceeds value");

    a_sat_rem_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSB-1] && fs.op == hsvc_pkg::OP_RGB2HSV && fs.mx != 8'd0 |->
            divb_rem < hsvc_pkg::DivBNumW'(fs.mx))
        else $error("saturation remainder not below max channel");

endmodule

`default_nettype wire
